/* hw/rtl/grid_ray_cast_dda_macros.svh */
// Assertion macros shared by the ray caster RTL.
// Expects signals named clk and rst in the including scope.
`ifndef GRID_RAY_CAST_DDA_MACROS_SVH
`define GRID_RAY_CAST_DDA_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grc assertion failed");

// Next-cycle implication, disabled during reset.
`define GRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grc assertion failed");

`endif

/* hw/rtl/grc_pkg.sv */
// Shared constants for the grid ray caster.
// No dependencies.
package grc_pkg;

  localparam int POS_W   = 24;
  localparam int DIR_W   = 18;
  localparam int SCRW_W  = 12;
  localparam int DIST_W  = 24;
  localparam int FRAC_W  = 16;
  localparam int RAY_W   = 33;
  localparam int CELL_W  = 10;
  localparam int CIDX_W  = 5;
  localparam int REG_W   = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_OUT   = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic [REG_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [REG_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [REG_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [REG_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [REG_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [REG_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [REG_W-1:0] REG_WIDTH   = 3'd6;

endpackage

/* hw/rtl/grc_if.sv */
// Valid/ready channel interfaces of the ray caster: request, result, register write.
// Depends on grc_pkg.
interface grc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [grc_pkg::CIDX_W-1:0]       cell_col;
  logic [grc_pkg::CIDX_W-1:0]       cell_row;
  logic                             cell_solid;
  logic [grc_pkg::SCRW_W-1:0]       column;
  modport source (output valid, func, cell_col, cell_row, cell_solid, column, input ready);
  modport sink   (input valid, func, cell_col, cell_row, cell_solid, column, output ready);
endinterface

interface grc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [grc_pkg::DIST_W-1:0]       distance;
  logic [grc_pkg::FRAC_W-1:0]       wall_frac;
  logic                             hit_x_side;
  logic [1:0]                       status;
  modport source (output valid, distance, wall_frac, hit_x_side, status, input ready);
  modport sink   (input valid, distance, wall_frac, hit_x_side, status, output ready);
endinterface

interface grc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [grc_pkg::REG_W-1:0]        index;
  logic [grc_pkg::POS_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/grc_div.sv */
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module grc_div #(
  parameter int NW = 46,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNT_W = $clog2(NW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dreg;
  logic [NW-1:0]    q;
  logic [DW:0]      sh;
  logic             ge;

  always_comb begin
    sh = {rem, q[NW-1]};
    ge = (sh >= {1'b0, dreg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= num;
        dreg <= den;
      end else if (busy) begin
        rem <= ge ? DW'(sh - {1'b0, dreg}) : DW'(sh);
        q   <= {q[NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
endmodule

/* hw/rtl/grc_mul.sv */
// Shift-add multiplier on magnitudes, sign applied at the end, result mod 2^W.
// No dependencies.
module grc_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         neg,
  output logic         done,
  output logic [W-1:0] prod
);
  logic         busy;
  logic         nreg;
  logic [W-1:0] acc;
  logic [W-1:0] areg;
  logic [W-1:0] breg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        areg <= a;
        breg <= b;
        nreg <= neg;
      end else if (busy) begin
        if (breg == '0) begin
          // finish once the multiplier operand runs out of ones
          busy <= 1'b0;
          done <= 1'b1;
          prod <= nreg ? W'(-acc) : acc;
        end else begin
          if (breg[0]) acc <= acc + areg;
          areg <= {areg[W-2:0], 1'b0};
          breg <= {1'b0, breg[W-1:1]};
        end
      end
    end
  end
endmodule

/* hw/rtl/grc_map_ram.sv */
// One-bit grid map store: one write port, one registered read port.
// No dependencies.
module grc_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/grid_ray_cast_dda.sv */
// Grid ray caster: a func 0 beat stores one map cell; a func 1 beat casts one
// screen column and yields one result beat (distance, wall fraction, side,
// status). After reset the map is swept clear with req.ready low; register
// writes are taken throughout. A cast runs on one restoring divider (up to
// three divisions: camera coordinate and the two axis deltas), one shift-add
// multiplier (up to five uses) and the map read port (a read at the origin and
// one per grid step, up to MAX_STEPS steps). A finished result waits in the
// output register; the next beat is taken while it waits.
module grid_ray_cast_dda #(
  parameter int MAP_COLS  = 32,
  parameter int MAP_ROWS  = 32,
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  grc_req_if.sink     req,
  grc_rsp_if.source   rsp,
  grc_cfg_if.sink     cfg
);
  `include "grid_ray_cast_dda_macros.svh"

  localparam int F      = FRAC_BITS;
  localparam int NW     = 2 * F + 14;
  localparam int DW     = grc_pkg::RAY_W;
  localparam int MW     = 2 * F + 32;
  localparam int CAM_W  = F + 15;
  localparam int SW     = F + 22;
  localparam int DLT_W  = F + 13;
  localparam int DEPTH  = MAP_COLS * MAP_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int NSW    = $clog2(MAX_STEPS + 1);
  localparam int CW     = grc_pkg::CELL_W;
  localparam int RW     = grc_pkg::RAY_W;
  localparam int SH_R   = (F >= 16) ? F - 16 : 0;
  localparam int SH_L   = (F >= 16) ? 0 : 16 - F;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CAM    = 5'd2;
  localparam logic [4:0] S_MRX    = 5'd3;
  localparam logic [4:0] S_MRY    = 5'd4;
  localparam logic [4:0] S_ORG    = 5'd5;
  localparam logic [4:0] S_ORGCHK = 5'd6;
  localparam logic [4:0] S_DLX0   = 5'd7;
  localparam logic [4:0] S_DLX    = 5'd8;
  localparam logic [4:0] S_DLY0   = 5'd9;
  localparam logic [4:0] S_DLY    = 5'd10;
  localparam logic [4:0] S_SX0    = 5'd11;
  localparam logic [4:0] S_SX     = 5'd12;
  localparam logic [4:0] S_SY     = 5'd13;
  localparam logic [4:0] S_STEP   = 5'd14;
  localparam logic [4:0] S_RDREQ  = 5'd15;
  localparam logic [4:0] S_RDCHK  = 5'd16;
  localparam logic [4:0] S_FRAC0  = 5'd17;
  localparam logic [4:0] S_FRAC   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  // configuration registers
  logic [grc_pkg::POS_W-1:0]         pos_x, pos_y;
  logic signed [grc_pkg::DIR_W-1:0]  dir_x, dir_y, plane_x, plane_y;
  logic [grc_pkg::SCRW_W-1:0]        scr_w;

  // sequencer state
  logic [4:0]              state;
  logic [AW-1:0]           clr_addr;
  logic [MW-1:0]           cam_mag;
  logic                    cam_neg;
  logic signed [RW-1:0]    rx, ry;
  logic [DLT_W-1:0]        dlx, dly;
  logic [SW-1:0]           sx, sy, walk_dist;
  logic signed [CW-1:0]    cx, cy;
  logic                    side;
  logic [NSW-1:0]          n_steps;
  logic                    start_out;
  logic [grc_pkg::DIST_W-1:0] res_dist;
  logic [grc_pkg::FRAC_W-1:0] res_frac;
  logic                    res_side;
  logic [1:0]              res_status;

  // output register
  logic                       out_valid;
  logic [grc_pkg::DIST_W-1:0] out_dist;
  logic [grc_pkg::FRAC_W-1:0] out_frac;
  logic                       out_side;
  logic [1:0]                 out_status;

  // shared units
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [DW-1:0] div_den;
  logic          mul_start, mul_done, mul_neg;
  logic [MW-1:0] mul_a, mul_b, mul_prod;

  // map port
  logic          map_we, map_wdata, map_re, map_rdata;
  logic [AW-1:0] map_waddr, map_raddr;

  // combinational helpers
  logic                    req_acc;
  logic [24:0]             cx_full, cy_full;
  logic signed [CAM_W-1:0] camv;
  logic signed [MW-1:0]    prod_sh;
  logic [MW-1:0]           px_abs, py_abs;
  logic [RW-1:0]           rx_abs, ry_abs;
  logic [NW-1:0]           dl_cap;
  logic [F:0]              fx, fy;
  logic                    take_x;
  logic                    cell_out;
  logic [F-1:0]            pf;
  logic [grc_pkg::FRAC_W-1:0] pos_q16, pf_q16;
  logic [grc_pkg::DIST_W-1:0] dist_sat;

  grc_div #(.NW(NW), .DW(DW)) u_div (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num), .den (div_den),
    .done (div_done), .quot (div_quot)
  );

  grc_mul #(.W(MW)) u_mul (
    .clk (clk), .rst (rst), .start (mul_start), .a (mul_a), .b (mul_b),
    .neg (mul_neg), .done (mul_done), .prod (mul_prod)
  );

  grc_map_ram #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk (clk), .we (map_we), .waddr (map_waddr), .wdata (map_wdata),
    .re (map_re), .raddr (map_raddr), .rdata (map_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.distance   = out_dist;
  assign rsp.wall_frac  = out_frac;
  assign rsp.hit_x_side = out_side;
  assign rsp.status     = out_status;

  always_comb begin
    // start cell in whole-cell units, kept wide for the range check
    cx_full = 25'(pos_x) >> F;
    cy_full = 25'(pos_y) >> F;
    camv    = signed'(CAM_W'(div_quot)) - (signed'(CAM_W'(1)) <<< F);
    prod_sh = signed'(mul_prod) >>> F;
    px_abs  = plane_x[grc_pkg::DIR_W-1] ? MW'(-MW'(plane_x)) : MW'(plane_x);
    py_abs  = plane_y[grc_pkg::DIR_W-1] ? MW'(-MW'(plane_y)) : MW'(plane_y);
    rx_abs  = rx[RW-1] ? RW'(-rx) : RW'(rx);
    ry_abs  = ry[RW-1] ? RW'(-ry) : RW'(ry);
    // cap the axis delta at 2^12 cells
    dl_cap  = (div_quot > (NW'(1) << (F + 12))) ? (NW'(1) << (F + 12)) : div_quot;
    // distance to the first grid line along each axis
    fx = rx[RW-1] ? (F+1)'(pos_x[F-1:0]) : ((F+1)'(1) << F) - (F+1)'(pos_x[F-1:0]);
    fy = ry[RW-1] ? (F+1)'(pos_y[F-1:0]) : ((F+1)'(1) << F) - (F+1)'(pos_y[F-1:0]);
    take_x   = (rx != '0) && ((ry == '0) || (sx < sy));
    cell_out = (cx < 0) || (cx >= MAP_COLS) || (cy < 0) || (cy >= MAP_ROWS);
    pf       = F'(mul_prod >> F) + (side ? pos_y[F-1:0] : pos_x[F-1:0]);
    pos_q16  = 16'((40'(pos_x[F-1:0]) >> SH_R) << SH_L);
    pf_q16   = 16'((40'(pf) >> SH_R) << SH_L);
    dist_sat = (walk_dist > SW'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX :
               grc_pkg::DIST_W'(walk_dist);
  end

  // map port: clearing sweep, then beat writes; reads on origin and grid steps
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr;
    map_wdata = 1'b0;
    if (state == S_CLEAR) begin
      map_we = 1'b1;
    end else if (req_acc && (req.func == grc_pkg::FUNC_WRITE) &&
                 (int'(req.cell_col) < MAP_COLS) && (int'(req.cell_row) < MAP_ROWS)) begin
      map_we    = 1'b1;
      map_waddr = AW'(int'(req.cell_row) * MAP_COLS + int'(req.cell_col));
      map_wdata = req.cell_solid;
    end
    map_re    = ((state == S_ORG) && !start_out) || ((state == S_RDREQ) && !cell_out);
    map_raddr = AW'(int'(cy) * MAP_COLS + int'(cx));
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 24'd98304;
      pos_y   <= 24'd98304;
      dir_x   <= 18'sd65536;
      dir_y   <= 18'sd0;
      plane_x <= 18'sd0;
      plane_y <= 18'sd43253;
      scr_w   <= 12'd640;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        grc_pkg::REG_POS_X:   pos_x   <= cfg.data;
        grc_pkg::REG_POS_Y:   pos_y   <= cfg.data;
        grc_pkg::REG_DIR_X:   dir_x   <= signed'(cfg.data[grc_pkg::DIR_W-1:0]);
        grc_pkg::REG_DIR_Y:   dir_y   <= signed'(cfg.data[grc_pkg::DIR_W-1:0]);
        grc_pkg::REG_PLANE_X: plane_x <= signed'(cfg.data[grc_pkg::DIR_W-1:0]);
        grc_pkg::REG_PLANE_Y: plane_y <= signed'(cfg.data[grc_pkg::DIR_W-1:0]);
        grc_pkg::REG_WIDTH:   scr_w   <= cfg.data[grc_pkg::SCRW_W-1:0];
        default: ;
      endcase
    end
  end

  // output register: load a finished result when free or being taken, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_dist   <= res_dist;
      out_frac   <= res_frac;
      out_side   <= res_side;
      out_status <= res_status;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_start <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_acc && (req.func == grc_pkg::FUNC_CAST)) begin
            // camera coordinate numerator: 2*column in fixed point
            div_start <= 1'b1;
            div_num   <= NW'(req.column) << (F + 1);
            div_den   <= (scr_w == '0) ? DW'(1) : DW'(scr_w);
            start_out <= (cx_full >= 25'(MAP_COLS)) || (cy_full >= 25'(MAP_ROWS));
            cx        <= CW'(cx_full);
            cy        <= CW'(cy_full);
            state     <= S_CAM;
          end
        end
        S_CAM: begin
          if (div_done) begin
            cam_neg   <= camv[CAM_W-1];
            cam_mag   <= camv[CAM_W-1] ? MW'(-MW'(camv)) : MW'(camv);
            mul_start <= 1'b1;
            mul_a     <= camv[CAM_W-1] ? MW'(-MW'(camv)) : MW'(camv);
            mul_b     <= px_abs;
            mul_neg   <= camv[CAM_W-1] ^ plane_x[grc_pkg::DIR_W-1];
            state     <= S_MRX;
          end
        end
        S_MRX: begin
          if (mul_done) begin
            rx        <= RW'(dir_x) - RW'(prod_sh);
            mul_start <= 1'b1;
            mul_a     <= cam_mag;
            mul_b     <= py_abs;
            mul_neg   <= cam_neg ^ plane_y[grc_pkg::DIR_W-1];
            state     <= S_MRY;
          end
        end
        S_MRY: begin
          if (mul_done) begin
            ry    <= RW'(dir_y) - RW'(prod_sh);
            state <= S_ORG;
          end
        end
        S_ORG: begin
          res_dist <= '0;
          res_frac <= '0;
          res_side <= 1'b0;
          if (start_out) begin
            res_status <= grc_pkg::ST_OUT;
            state      <= S_DONE;
          end else begin
            state <= S_ORGCHK;
          end
        end
        S_ORGCHK: begin
          if (map_rdata) begin
            // started inside a wall
            res_frac   <= pos_q16;
            res_status <= grc_pkg::ST_HIT;
            state      <= S_DONE;
          end else if ((rx == '0) && (ry == '0)) begin
            res_dist   <= grc_pkg::DIST_MAX;
            res_status <= grc_pkg::ST_LIMIT;
            state      <= S_DONE;
          end else begin
            state <= S_DLX0;
          end
        end
        S_DLX0: begin
          if (rx == '0) begin
            dlx   <= DLT_W'(1) << (F + 12);
            state <= S_DLY0;
          end else begin
            div_start <= 1'b1;
            div_num   <= NW'(1) << (2 * F);
            div_den   <= DW'(rx_abs);
            state     <= S_DLX;
          end
        end
        S_DLX: begin
          if (div_done) begin
            dlx   <= DLT_W'(dl_cap);
            state <= S_DLY0;
          end
        end
        S_DLY0: begin
          if (ry == '0) begin
            dly   <= DLT_W'(1) << (F + 12);
            state <= S_SX0;
          end else begin
            div_start <= 1'b1;
            div_num   <= NW'(1) << (2 * F);
            div_den   <= DW'(ry_abs);
            state     <= S_DLY;
          end
        end
        S_DLY: begin
          if (div_done) begin
            dly   <= DLT_W'(dl_cap);
            state <= S_SX0;
          end
        end
        S_SX0: begin
          mul_start <= 1'b1;
          mul_a     <= MW'(dlx);
          mul_b     <= MW'(fx);
          mul_neg   <= 1'b0;
          state     <= S_SX;
        end
        S_SX: begin
          if (mul_done) begin
            sx        <= SW'(mul_prod >> F);
            mul_start <= 1'b1;
            mul_a     <= MW'(dly);
            mul_b     <= MW'(fy);
            mul_neg   <= 1'b0;
            state     <= S_SY;
          end
        end
        S_SY: begin
          if (mul_done) begin
            sy      <= SW'(mul_prod >> F);
            n_steps <= '0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          // advance across the nearer grid line
          if (take_x) begin
            walk_dist <= sx;
            sx        <= sx + SW'(dlx);
            cx        <= rx[RW-1] ? cx - CW'(1) : cx + CW'(1);
            side      <= 1'b1;
          end else begin
            walk_dist <= sy;
            sy        <= sy + SW'(dly);
            cy        <= ry[RW-1] ? cy - CW'(1) : cy + CW'(1);
            side      <= 1'b0;
          end
          n_steps <= n_steps + 1'b1;
          state   <= S_RDREQ;
        end
        S_RDREQ: begin
          if (cell_out) begin
            res_status <= grc_pkg::ST_OUT;
            state      <= S_FRAC0;
          end else begin
            state <= S_RDCHK;
          end
        end
        S_RDCHK: begin
          if (map_rdata) begin
            res_status <= grc_pkg::ST_HIT;
            state      <= S_FRAC0;
          end else if (n_steps == NSW'(MAX_STEPS)) begin
            res_status <= grc_pkg::ST_LIMIT;
            state      <= S_FRAC0;
          end else begin
            state <= S_STEP;
          end
        end
        S_FRAC0: begin
          // hit coordinate along the wall: walk distance times the other ray axis
          res_dist  <= dist_sat;
          res_side  <= side;
          mul_start <= 1'b1;
          mul_a     <= MW'(walk_dist);
          mul_b     <= side ? MW'(ry_abs) : MW'(rx_abs);
          mul_neg   <= side ? ry[RW-1] : rx[RW-1];
          state     <= S_FRAC;
        end
        S_FRAC: begin
          if (mul_done) begin
            res_frac <= pf_q16;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GRC_ASSERT_IMP(a_ready_idle, req.ready, state == S_IDLE)
  `GRC_ASSERT_IMP(a_step_bound, state == S_STEP, n_steps < NSW'(MAX_STEPS))
  `GRC_ASSERT_NXT(a_write_one_cycle, req_acc && (req.func == grc_pkg::FUNC_WRITE), state == S_IDLE)
  `GRC_ASSERT_IMP(a_mul_owner, mul_done, (state == S_MRX) || (state == S_MRY) || (state == S_SX) || (state == S_SY) || (state == S_FRAC))
  `GRC_ASSERT_IMP(a_div_owner, div_done, (state == S_CAM) || (state == S_DLX) || (state == S_DLY))
endmodule

/* tb/sv/tb_grid_ray_cast_dda.sv */
// Testbench for the grid ray caster: a directed table, then random phases of
// map writes and column casts, checked beat by beat against an in-bench predictor or a typed expectation.
// Depends on grc_pkg, the grc_*_if interfaces and grid_ray_cast_dda.
`timescale 1ns / 1ps
module tb_grid_ray_cast_dda;

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam int STEP_CAP = 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 700;      // one full cast with margin
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic [grc_pkg::DIST_W-1:0] distance;
    logic [grc_pkg::FRAC_W-1:0] wall_frac;
    logic                       hit_x_side;
    logic [1:0]                 status;
  } cast_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_CAST} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [grc_pkg::REG_W-1:0] idx;
    logic [grc_pkg::POS_W-1:0] val;
    logic [4:0]                col;
    logic [4:0]                row;
    logic                      solid;
    logic [11:0]               column;
    bit                        typed;
    cast_result_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  grc_req_if req_ch();
  grc_rsp_if rsp_ch();
  grc_cfg_if cfg_ch();

  grid_ray_cast_dda dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's registers and map, updated on accepted beats.
  logic [grc_pkg::POS_W-1:0]        cam_px, cam_py;
  logic signed [grc_pkg::DIR_W-1:0] view_dx, view_dy, plane_dx, plane_dy;
  logic [grc_pkg::SCRW_W-1:0]       scr_width;
  bit                               wall_map [COLS*ROWS];

  cast_result_t pending_casts [$];
  int           errors = 0;
  int           cycles = 0;

  // Typed expectation for the beat on the bus, driven alongside it.
  bit           typed_on;
  cast_result_t typed_want;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  stim_row_t plan [$];

  function automatic longint unsigned axis_span(longint d);
    longint unsigned m, q;
    if (d == 0) return 64'd1 << 28;
    m = (d < 0) ? -d : d;
    q = (64'd1 << 32) / m;
    return (q > (64'd1 << 28)) ? (64'd1 << 28) : q;
  endfunction

  // Walk the grid from the camera along the ray of one screen column.
  function automatic cast_result_t trace_column(logic [11:0] column);
    cast_result_t r;
    longint w, cam, rx, ry, cx, cy, stx, sty;
    longint unsigned dlx, dly, fx, fy, sx, sy, hit_dist, p;
    logic [1:0] status;
    bit side, stop;
    int n;
    r = '0;
    hit_dist = 0;
    side = 0;
    status = grc_pkg::ST_LIMIT;
    w = (scr_width == 0) ? 1 : longint'(scr_width);
    cam = ((longint'(column) * 2) <<< 16) / w - 65536;
    rx = longint'(view_dx) - ((longint'(plane_dx) * cam) >>> 16);
    ry = longint'(view_dy) - ((longint'(plane_dy) * cam) >>> 16);
    cx = longint'(cam_px >> 16);
    cy = longint'(cam_py >> 16);
    if (cx >= COLS || cy >= ROWS) begin
      r.status = grc_pkg::ST_OUT;
      return r;
    end
    if (wall_map[cy*COLS + cx]) begin
      r.wall_frac = cam_px[15:0];
      r.status = grc_pkg::ST_HIT;
      return r;
    end
    if (rx == 0 && ry == 0) begin
      r.distance = grc_pkg::DIST_MAX;
      r.status = grc_pkg::ST_LIMIT;
      return r;
    end
    dlx = axis_span(rx);
    dly = axis_span(ry);
    fx = cam_px[15:0];
    fy = cam_py[15:0];
    if (rx < 0) stx = -1; else begin stx = 1; fx = 65536 - fx; end
    if (ry < 0) sty = -1; else begin sty = 1; fy = 65536 - fy; end
    sx = (fx * dlx) >> 16;
    sy = (fy * dly) >> 16;
    stop = 0;
    for (n = 0; n < STEP_CAP && !stop; n++) begin
      if (rx != 0 && (ry == 0 || sx < sy)) begin
        hit_dist = sx; sx += dlx; cx += stx; side = 1;
      end else begin
        hit_dist = sy; sy += dly; cy += sty; side = 0;
      end
      if (cx < 0 || cx >= COLS || cy < 0 || cy >= ROWS) begin
        status = grc_pkg::ST_OUT; stop = 1;
      end else if (wall_map[cy*COLS + cx]) begin
        status = grc_pkg::ST_HIT; stop = 1;
      end
    end
    // the loop counter moved past the breaking step; any step taken counts
    if (n > 0 || status != grc_pkg::ST_LIMIT) begin
      if (side) p = ((hit_dist * longint'(ry)) >> 16) + cam_py;
      else p = ((hit_dist * longint'(rx)) >> 16) + cam_px;
      r.wall_frac = p[15:0];
    end
    r.distance = (hit_dist > 64'hFFFFFF) ? grc_pkg::DIST_MAX : hit_dist[23:0];
    r.hit_x_side = side;
    r.status = status;
    return r;
  endfunction

  // Sample every channel at the edge: track registers and map, queue and check casts.
  always @(posedge clk) begin
    cast_result_t got, want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          grc_pkg::REG_POS_X:   cam_px    = cfg_ch.data;
          grc_pkg::REG_POS_Y:   cam_py    = cfg_ch.data;
          grc_pkg::REG_DIR_X:   view_dx   = cfg_ch.data[grc_pkg::DIR_W-1:0];
          grc_pkg::REG_DIR_Y:   view_dy   = cfg_ch.data[grc_pkg::DIR_W-1:0];
          grc_pkg::REG_PLANE_X: plane_dx  = cfg_ch.data[grc_pkg::DIR_W-1:0];
          grc_pkg::REG_PLANE_Y: plane_dy  = cfg_ch.data[grc_pkg::DIR_W-1:0];
          grc_pkg::REG_WIDTH:   scr_width = cfg_ch.data[grc_pkg::SCRW_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.func == grc_pkg::FUNC_WRITE)
          wall_map[req_ch.cell_row*COLS + req_ch.cell_col] = req_ch.cell_solid;
        else
          pending_casts.push_back(typed_on ? typed_want : trace_column(req_ch.column));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.distance, rsp_ch.wall_frac, rsp_ch.hit_x_side, rsp_ch.status};
        if (pending_casts.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = pending_casts.pop_front();
          if (got.distance !== want.distance) begin
            errors++;
            $display("%0t: distance expected %h actual %h", $time, want.distance, got.distance);
          end
          if (got.wall_frac !== want.wall_frac) begin
            errors++;
            $display("%0t: wall_frac expected %h actual %h", $time, want.wall_frac,
                     got.wall_frac);
          end
          if (got.hit_x_side !== want.hit_x_side) begin
            errors++;
            $display("%0t: hit_x_side expected %b actual %b", $time, want.hit_x_side,
                     got.hit_x_side);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one request beat and hold it until taken; then maybe go idle.
  task automatic send_beat(logic func, logic [4:0] col, logic [4:0] row, logic solid,
                           logic [11:0] column, bit typed, cast_result_t want);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.cell_col   <= col;
    req_ch.cell_row   <= row;
    req_ch.cell_solid <= solid;
    req_ch.column     <= column;
    typed_on          <= typed;
    typed_want        <= want;
    do @(posedge clk); while (!req_ch.ready);
    if ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering, wait out every pending cast and let the block settle.
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_casts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [grc_pkg::REG_W-1:0] idx, logic [grc_pkg::POS_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stim_row_t row_cfg(logic [grc_pkg::REG_W-1:0] idx,
                                        logic [grc_pkg::POS_W-1:0] val);
    stim_row_t s;
    s = '{kind: ROW_CFG, default: '0};
    s.idx = idx; s.val = val;
    return s;
  endfunction

  function automatic stim_row_t row_wr(logic [4:0] c, logic [4:0] r, logic solid);
    stim_row_t s;
    s = '{kind: ROW_WRITE, default: '0};
    s.col = c; s.row = r; s.solid = solid;
    return s;
  endfunction

  function automatic stim_row_t row_cast(logic [11:0] column, bit typed, cast_result_t want);
    stim_row_t s;
    s = '{kind: ROW_CAST, default: '0};
    s.column = column; s.typed = typed; s.want = want;
    return s;
  endfunction

  function automatic logic [grc_pkg::POS_W-1:0] rand_pos();
    if ($urandom_range(99) < 8) return grc_pkg::POS_W'($urandom);
    return {8'($urandom_range(0, 31)), 16'($urandom)};
  endfunction

  initial begin
    cast_result_t none;
    logic [grc_pkg::SCRW_W-1:0] w;
    logic [11:0] column;
    int n_items;
    none = '0;
    req_ch.valid = 1'b0; req_ch.func = grc_pkg::FUNC_WRITE; req_ch.cell_col = '0;
    req_ch.cell_row = '0; req_ch.cell_solid = 1'b0; req_ch.column = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    typed_on = 0; typed_want = '0;
    cam_px = 24'd98304; cam_py = 24'd98304;
    view_dx = 18'sd65536; view_dy = '0; plane_dx = '0; plane_dy = 18'sd43253;
    scr_width = 12'd640;
    foreach (wall_map[i]) wall_map[i] = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset defaults, camera inside a wall, off-map start,
    // zero ray, extreme directions, zero and full screen width.
    plan.push_back(row_cast(12'd0, 0, none));
    plan.push_back(row_wr(5'd1, 5'd1, 1'b1));
    plan.push_back(row_cast(12'd320, 1, '{24'd0, 16'h8000, 1'b0, grc_pkg::ST_HIT}));
    plan.push_back(row_wr(5'd1, 5'd1, 1'b0));
    plan.push_back(row_wr(5'd31, 5'd31, 1'b1));
    plan.push_back(row_wr(5'd0, 5'd0, 1'b1));
    plan.push_back(row_wr(5'd6, 5'd1, 1'b1));
    plan.push_back(row_cast(12'd320, 0, none));
    plan.push_back(row_cfg(grc_pkg::REG_POS_X, 24'hFFFFFF));
    plan.push_back(row_cast(12'd0, 1, '{24'd0, 16'd0, 1'b0, grc_pkg::ST_OUT}));
    plan.push_back(row_cfg(grc_pkg::REG_POS_X, 24'd98304));
    plan.push_back(row_cfg(grc_pkg::REG_DIR_X, 24'd0));
    plan.push_back(row_cfg(grc_pkg::REG_PLANE_Y, 24'd0));
    plan.push_back(row_cast(12'd5, 1, '{grc_pkg::DIST_MAX, 16'd0, 1'b0, grc_pkg::ST_LIMIT}));
    plan.push_back(row_cfg(grc_pkg::REG_DIR_X, 24'h01FFFF));
    plan.push_back(row_cast(12'd0, 0, none));
    plan.push_back(row_cfg(grc_pkg::REG_DIR_Y, 24'h020000));
    plan.push_back(row_cast(12'd4095, 0, none));
    plan.push_back(row_cfg(grc_pkg::REG_PLANE_X, 24'h01FFFF));
    plan.push_back(row_cfg(grc_pkg::REG_PLANE_Y, 24'h020000));
    plan.push_back(row_cfg(grc_pkg::REG_WIDTH, 24'd0));
    plan.push_back(row_cast(12'd0, 0, none));
    plan.push_back(row_cast(12'd4095, 0, none));
    plan.push_back(row_cfg(grc_pkg::REG_WIDTH, 24'd4095));
    plan.push_back(row_cast(12'd4095, 0, none));
    plan.push_back(row_cast(12'd2047, 0, none));
    plan.push_back(row_cfg(grc_pkg::REG_POS_Y, 24'd0));
    plan.push_back(row_cast(12'd100, 0, none));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          drain_block();
          write_reg(plan[i].idx, plan[i].val);
        end
        ROW_WRITE: send_beat(grc_pkg::FUNC_WRITE, plan[i].col, plan[i].row, plan[i].solid,
                             '0, 0, none);
        default: send_beat(grc_pkg::FUNC_CAST, '0, '0, 1'b0, plan[i].column, plan[i].typed,
                           plan[i].want);
      endcase
    end

    // Random phases; each cycles the idling mode and reprograms every register.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      drain_block();
      write_reg(grc_pkg::REG_POS_X, rand_pos());
      write_reg(grc_pkg::REG_POS_Y, rand_pos());
      write_reg(grc_pkg::REG_DIR_X,
                (ph == 3) ? 24'h01FFFF : (ph == 6) ? 24'h020000 : 24'($urandom));
      write_reg(grc_pkg::REG_DIR_Y, (ph == 4) ? 24'h020000 : 24'($urandom));
      write_reg(grc_pkg::REG_PLANE_X, (ph == 5) ? 24'h01FFFF : 24'($urandom));
      write_reg(grc_pkg::REG_PLANE_Y, (ph == 7) ? 24'h000000 : 24'($urandom));
      case ($urandom_range(5))
        0: w = 12'd0;
        1: w = 12'd1;
        2: w = 12'd4095;
        default: w = 12'($urandom_range(2, 640));
      endcase
      if (ph == 0) w = 12'd4095;
      if (ph == 1) w = 12'd1;
      write_reg(grc_pkg::REG_WIDTH, {12'd0, w});

      // Build walls: random cells in the left and right edge columns on most phases, scattered blocks across the map.
      for (int k = 0; k < 30; k++) begin
        if (ph != 2 && k < 16)
          send_beat(grc_pkg::FUNC_WRITE, (k % 2) ? 5'd31 : 5'd0, 5'($urandom), 1'b1, '0, 0,
                    none);
        else
          send_beat(grc_pkg::FUNC_WRITE, 5'($urandom), 5'($urandom),
                    $urandom_range(99) < 35, '0, 0, none);
      end

      n_items = 160;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 2 && k == 20) hold_req++;
        if (ph == 5 && k == 80) drain_block();
        if ($urandom_range(99) < 15) begin
          send_beat(grc_pkg::FUNC_WRITE, 5'($urandom), 5'($urandom),
                    $urandom_range(99) < 30, '0, 0, none);
        end else begin
          if ($urandom_range(99) < 88 && w > 1) column = 12'($urandom_range(0, w - 1));
          else column = 12'($urandom);
          send_beat(grc_pkg::FUNC_CAST, '0, '0, 1'b0, column, 0, none);
        end
      end
    end

    drain_block();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/grc_pkg.sv
hw/rtl/grc_if.sv
hw/rtl/grc_div.sv
hw/rtl/grc_mul.sv
hw/rtl/grc_map_ram.sv
hw/rtl/grid_ray_cast_dda.sv
tb/sv/tb_grid_ray_cast_dda.sv
